### hw/rtl/mf5_pkg.sv
// Package for the five-tap sliding-window median filter.
// Holds the window size, field types and the status struct shared by the
// window store, the rank selector and the top level. Depends on nothing.
`default_nettype none

package mf5_pkg;

  localparam int WINDOW = 5;
  localparam int CENTRE = WINDOW / 2;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int RANK_W = $clog2(WINDOW);

  localparam int TIME_W  = 31;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 32;

  typedef logic [TIME_W-1:0]         time_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [FILL_W-1:0]         fill_t;
  typedef logic [RANK_W-1:0]         rank_t;

  typedef value_t [WINDOW-1:0] value_win_t;
  typedef time_t  [WINDOW-1:0] time_win_t;

  // What the window store reports about the beat it is about to absorb.
  typedef struct packed {
    logic   emit;
    count_t count;
  } win_stat_t;

endpackage

`default_nettype wire

### hw/rtl/mf5_window.sv
// Sample window store: shift line of values and timestamps, fill level and
// result count for the current series. Uses mf5_pkg.
`default_nettype none

module mf5_window (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 take,
  input  wire                 start_series,
  input  mf5_pkg::time_t      sample_time,
  input  mf5_pkg::value_t     sample_value,
  output mf5_pkg::value_win_t nxt_values,
  output mf5_pkg::time_win_t  nxt_times,
  output mf5_pkg::win_stat_t  stat
);
  import mf5_pkg::*;

  value_win_t values_r;
  time_win_t  times_r;
  fill_t      fill_r;
  fill_t      fill_eff;
  fill_t      fill_nxt;
  count_t     count_r;
  count_t     count_eff;
  count_t     count_nxt;
  logic       emit;

  // Entries left over from an earlier series are shifted out before the
  // window counts as full, so a start only needs to clear the counters.
  always_comb begin
    fill_eff  = start_series ? '0 : fill_r;
    count_eff = start_series ? '0 : count_r;
    emit      = (fill_eff >= fill_t'(WINDOW - 1));
    fill_nxt  = emit ? fill_t'(WINDOW) : fill_eff + fill_t'(1);
    count_nxt = emit ? count_eff + count_t'(1) : count_eff;
    for (int i = 0; i < WINDOW - 1; i++) begin
      nxt_values[i] = values_r[i+1];
      nxt_times[i]  = times_r[i+1];
    end
    nxt_values[WINDOW-1] = sample_value;
    nxt_times[WINDOW-1]  = sample_time;
  end

  assign stat.emit  = emit;
  assign stat.count = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      count_r <= '0;
    end else if (take) begin
      fill_r  <= fill_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      values_r <= nxt_values;
      times_r  <= nxt_times;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mf5_rank.sv
// Rank selector: picks the value of middle rank from the window by a
// parallel compare matrix and a rank count per entry. Uses mf5_pkg.
`default_nettype none

module mf5_rank (
  input  mf5_pkg::value_win_t values,
  output mf5_pkg::value_t     median
);
  import mf5_pkg::*;

  rank_t  rank [WINDOW];
  value_t pick;

  // Ties are broken by position, so every entry gets a distinct rank and
  // exactly one of them matches the centre rank.
  always_comb begin
    pick = '0;
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j != i) begin
          if (($signed(values[j]) < $signed(values[i])) ||
              ((values[j] == values[i]) && (j < i))) begin
            rank[i] = rank[i] + rank_t'(1);
          end
        end
      end
      if (rank[i] == rank_t'(CENTRE)) begin
        pick = pick | values[i];
      end
    end
  end

  assign median = pick;

endmodule

`default_nettype wire

### hw/rtl/median_filter_five_core.sv
// Top level of the five-tap sliding-window median filter.
// Joins the input register, the window store, the rank selector and the
// result register. Uses mf5_pkg, mf5_window and mf5_rank.
//
// Usage: samples arrive on the in_ channel, one beat per sample, each with
// its timestamp and a start flag. A beat with in_start_series high opens a
// new series: the window and the result count are cleared before that
// sample is taken. The first four samples of a series only fill the window.
// From the fifth onwards every sample yields one result beat on the out_
// channel carrying the timestamp of the middle sample in arrival order, the
// median of the five values and the number of results in the series.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. A sample is held first in the input register and its result
// then in the result register, each of which out_stall can hold.
// Throughput is one sample per cycle: the input register feeds the window
// update and rank compare matrix, which load the result register. When
// out_stall holds a result, a further result-bearing sample waits in the
// input register and in_stall rises; samples that bear no result still
// pass. Reset (rst_n low, synchronous) empties both registers and clears
// the fill level and count, so the next sample starts a series.
`default_nettype none

module median_filter_five_core (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire              in_start_series,
  input  mf5_pkg::time_t   in_sample_time,
  input  mf5_pkg::value_t  in_sample_value,
  output logic             out_valid,
  input  wire              out_stall,
  output mf5_pkg::time_t   out_centre_time,
  output mf5_pkg::value_t  out_median_value,
  output mf5_pkg::count_t  out_result_count
);
  import mf5_pkg::*;

  // Input register.
  logic       s1_valid_r;
  logic       s1_start_r;
  time_t      s1_time_r;
  value_t     s1_value_r;

  // Result register.
  logic       out_valid_r;
  time_t      out_time_r;
  value_t     out_median_r;
  count_t     out_count_r;

  value_win_t nxt_values;
  time_win_t  nxt_times;
  win_stat_t  stat;
  value_t     median;
  logic       out_free;
  logic       s1_go;
  logic       in_take;

  // The result register is free when it is empty or being read this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!stat.emit || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  mf5_window u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (s1_go),
    .start_series (s1_start_r),
    .sample_time  (s1_time_r),
    .sample_value (s1_value_r),
    .nxt_values   (nxt_values),
    .nxt_times    (nxt_times),
    .stat         (stat)
  );

  mf5_rank u_rank (
    .values (nxt_values),
    .median (median)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_start_r <= in_start_series;
      s1_time_r  <= in_sample_time;
      s1_value_r <= in_sample_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && stat.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && stat.emit) begin
      out_time_r   <= nxt_times[CENTRE];
      out_median_r <= median;
      out_count_r  <= stat.count;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_centre_time  = out_time_r;
  assign out_median_value = out_median_r;
  assign out_result_count = out_count_r;

endmodule

`default_nettype wire

### hw/rtl/mf5_checker.sv
// Port-level checker for median_filter_five_core, attached by bind.
// Uses mf5_pkg for the field types.
`default_nettype none

module mf5_checker (
  input wire              clk,
  input wire              rst_n,
  input wire              in_valid,
  input wire              in_stall,
  input wire              out_valid,
  input wire              out_stall,
  input mf5_pkg::count_t  out_result_count
);
  import mf5_pkg::*;

  // A held result beat stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // A held result beat keeps its count.
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result_count))
    else $error("result count changed while stalled");

  // The input only backs up behind a result that is itself held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // A result appearing from empty comes from a sample that passed through the input register into the result register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without a matching sample");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind median_filter_five_core mf5_checker u_mf5_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_count (out_result_count)
);

`default_nettype wire
